// ----- rtl/core/lrgbf_pkg.sv -----
`default_nettype none

package lrgbf_pkg;

    localparam int TIME_WIDTH    = 32;
    localparam int CHANNEL_WIDTH = 8;
    localparam int CHAN_NUM      = 3;
    localparam int CHAN_W        = $clog2(CHAN_NUM);
    localparam int BIT_W         = $clog2(CHANNEL_WIDTH);
    localparam int CFG_IDX_W     = 3;

    typedef logic [TIME_WIDTH-1:0]    time_t;
    typedef logic [CHANNEL_WIDTH-1:0] chan_t;

    localparam logic [CFG_IDX_W-1:0] CFG_START_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BLUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd6;

endpackage

`default_nettype wire

// ----- rtl/core/lrgbf_unit.sv -----
`default_nettype none

module lrgbf_unit
(
    input  wire lrgbf_pkg::time_t rem,
    input  wire lrgbf_pkg::time_t addend,
    input  wire lrgbf_pkg::time_t divisor,
    input  wire                   add_sel,
    output lrgbf_pkg::time_t      result,
    output logic                  ge
);

    logic [lrgbf_pkg::TIME_WIDTH:0] x;
    logic [lrgbf_pkg::TIME_WIDTH:0] diff;

    // either add the numerator step or double the remainder, then reduce once
    always_comb
    begin
        if (add_sel)
        begin
            x = {1'b0, rem} + {1'b0, addend};
        end
        else
        begin
            x = {rem, 1'b0};
        end
        ge   = (x >= {1'b0, divisor});
        diff = x - {1'b0, divisor};
        if (ge)
        begin
            result = diff[lrgbf_pkg::TIME_WIDTH-1:0];
        end
        else
        begin
            result = x[lrgbf_pkg::TIME_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/linear_rgb_fade_engine_core.sv -----
// operation: a request updates the elapsed time, then the shared divide step unit
// works one color channel after another; new requests are stalled until the result is out
//   (per color channel: 8 bits x double/add, then one rounding step)
// reset: rst_n clears elapsed time, finished flag, start/end color and duration registers
//   and the sequencer at once; no clearing pass
`default_nettype none

module linear_rgb_fade_engine_core
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_we,
    input  wire [lrgbf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire lrgbf_pkg::time_t                   cfg_data,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire lrgbf_pkg::time_t                   delta_us,
    input  wire                                     restart,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output lrgbf_pkg::chan_t                        red,
    output lrgbf_pkg::chan_t                        green,
    output lrgbf_pkg::chan_t                        blue,
    output lrgbf_pkg::time_t                        elapsed,
    output logic                                    done_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_DBL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int CW = lrgbf_pkg::CHANNEL_WIDTH;
    localparam int TW = lrgbf_pkg::TIME_WIDTH;

    lrgbf_pkg::chan_t start_reg [lrgbf_pkg::CHAN_NUM];
    lrgbf_pkg::chan_t end_reg   [lrgbf_pkg::CHAN_NUM];
    lrgbf_pkg::time_t dur_reg;

    logic [2:0]                       state_reg, state_next;
    lrgbf_pkg::time_t                 el_reg, el_next;
    logic                             fin_reg, fin_next;
    lrgbf_pkg::time_t                 delta_reg, delta_next;
    lrgbf_pkg::time_t                 r_reg, r_next;
    logic [CW:0]                      q_reg, q_next;
    logic [lrgbf_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic [lrgbf_pkg::CHAN_W-1:0]     chan_reg, chan_next;
    lrgbf_pkg::chan_t                 color_reg [lrgbf_pkg::CHAN_NUM];
    lrgbf_pkg::chan_t                 color_next [lrgbf_pkg::CHAN_NUM];
    logic                             out_valid_reg, out_valid_next;
    lrgbf_pkg::chan_t                 red_reg, red_next;
    lrgbf_pkg::chan_t                 green_reg, green_next;
    lrgbf_pkg::chan_t                 blue_reg, blue_next;
    lrgbf_pkg::time_t                 elapsed_reg, elapsed_next;
    logic                             done_reg, done_next;

    lrgbf_pkg::chan_t                 cur_start;
    lrgbf_pkg::chan_t                 cur_end;
    lrgbf_pkg::chan_t                 mag;
    logic                             rising;
    logic                             unit_add;
    lrgbf_pkg::time_t                 unit_rem;
    lrgbf_pkg::time_t                 unit_res;
    logic                             unit_ge;
    logic [TW:0]                      el_sum;
    logic [CW:0]                      q_round;
    lrgbf_pkg::chan_t                 chan_val;
    logic                             in_take;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign elapsed   = elapsed_reg;
    assign done_res  = done_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lrgbf_pkg::CHAN_NUM; i++)
            begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
            dur_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrgbf_pkg::CFG_START_RED:   start_reg[0] <= cfg_data[CW-1:0];
                lrgbf_pkg::CFG_START_GREEN: start_reg[1] <= cfg_data[CW-1:0];
                lrgbf_pkg::CFG_START_BLUE:  start_reg[2] <= cfg_data[CW-1:0];
                lrgbf_pkg::CFG_END_RED:     end_reg[0]   <= cfg_data[CW-1:0];
                lrgbf_pkg::CFG_END_GREEN:   end_reg[1]   <= cfg_data[CW-1:0];
                lrgbf_pkg::CFG_END_BLUE:    end_reg[2]   <= cfg_data[CW-1:0];
                lrgbf_pkg::CFG_DURATION:    dur_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cur_start = start_reg[chan_reg];
    assign cur_end   = end_reg[chan_reg];
    assign rising    = (cur_end > cur_start);
    assign mag       = rising ? (cur_end - cur_start) : (cur_start - cur_end);
    assign unit_add  = (state_reg == ST_ADD);
    assign unit_rem  = r_reg;
    assign el_sum    = {1'b0, el_reg} + {1'b0, delta_reg};
    assign q_round   = q_reg + {{CW{1'b0}}, unit_ge};

    lrgbf_unit u_unit
    (
        .rem     (unit_rem),
        .addend  (el_reg),
        .divisor (dur_reg),
        .add_sel (unit_add),
        .result  (unit_res),
        .ge      (unit_ge)
    );

    // final channel value from the rounded quotient, or the start or end value at the bounds
    always_comb
    begin
        if ((el_reg == '0) || (cur_start == cur_end))
        begin
            chan_val = cur_start;
        end
        else if (el_reg >= dur_reg)
        begin
            chan_val = cur_end;
        end
        else if (rising)
        begin
            chan_val = cur_start + q_round[CW-1:0];
        end
        else
        begin
            chan_val = cur_start - q_round[CW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        el_next        = el_reg;
        fin_next       = fin_reg;
        delta_next     = delta_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        chan_next      = chan_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && out_stall;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        elapsed_next   = elapsed_reg;
        done_next      = done_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    delta_next = delta_us;
                    if (restart)
                    begin
                        el_next  = '0;
                        fin_next = 1'b0;
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // el + delta >= dur is the same as delta >= dur - el here
                if (el_reg >= dur_reg)
                begin
                    fin_next = 1'b1;
                end
                else if (el_sum >= {1'b0, dur_reg})
                begin
                    el_next = dur_reg;
                end
                else
                begin
                    el_next = el_sum[TW-1:0];
                end
                r_next     = '0;
                q_next     = '0;
                bit_next   = lrgbf_pkg::BIT_W'(CW - 1);
                chan_next  = '0;
                state_next = ST_DBL;
            end
            ST_DBL:
            begin
                r_next     = unit_res;
                q_next     = {q_reg[CW-1:0], unit_ge};
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (mag[bit_reg])
                begin
                    r_next = unit_res;
                    q_next = q_reg + {{CW{1'b0}}, unit_ge};
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_RND;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_DBL;
                end
            end
            ST_RND:
            begin
                color_next[chan_reg] = chan_val;
                r_next   = '0;
                q_next   = '0;
                bit_next = lrgbf_pkg::BIT_W'(CW - 1);
                if (chan_reg == lrgbf_pkg::CHAN_W'(lrgbf_pkg::CHAN_NUM - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = ST_DBL;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    red_next       = color_reg[0];
                    green_next     = color_reg[1];
                    blue_next      = color_reg[2];
                    elapsed_next   = el_reg;
                    done_next      = fin_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            el_reg        <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            el_reg        <= el_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        bit_reg     <= bit_next;
        chan_reg    <= chan_next;
        color_reg   <= color_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        elapsed_reg <= elapsed_next;
        done_reg    <= done_next;
    end

    // busy right after a request is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("input not stalled after request taken");

    // a new result only comes out of the finish step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid && out_stall)) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish step");

    // channel counter stays within the color channels
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DBL || state_reg == ST_ADD || state_reg == ST_RND)
        |-> (chan_reg < lrgbf_pkg::CHAN_W'(lrgbf_pkg::CHAN_NUM)))
        else $error("channel counter out of range");

    // an elapsed time update never carries elapsed beyond the duration
    a_elapsed_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && el_reg < dur_reg) |=> (el_reg <= dur_reg))
        else $error("elapsed time passed the duration");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

    typedef struct {
        lrgbf_pkg::chan_t red;
        lrgbf_pkg::chan_t green;
        lrgbf_pkg::chan_t blue;
        lrgbf_pkg::time_t elapsed;
        logic             done;
    } fade_color_t;

    class fade_tracker;
        lrgbf_pkg::chan_t start_c [3];
        lrgbf_pkg::chan_t end_c [3];
        lrgbf_pkg::time_t duration;
        lrgbf_pkg::time_t elapsed_us;
        logic             finished;
        fade_color_t      colors_due [$];
        int               mismatches;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                start_c[i] = '0;
                end_c[i] = '0;
            end
            duration = '0;
            elapsed_us = '0;
            finished = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [lrgbf_pkg::CFG_IDX_W-1:0] idx, lrgbf_pkg::time_t val);
            case (idx)
                lrgbf_pkg::CFG_START_RED:   start_c[0] = val[lrgbf_pkg::CHANNEL_WIDTH-1:0];
                lrgbf_pkg::CFG_START_GREEN: start_c[1] = val[lrgbf_pkg::CHANNEL_WIDTH-1:0];
                lrgbf_pkg::CFG_START_BLUE:  start_c[2] = val[lrgbf_pkg::CHANNEL_WIDTH-1:0];
                lrgbf_pkg::CFG_END_RED:     end_c[0] = val[lrgbf_pkg::CHANNEL_WIDTH-1:0];
                lrgbf_pkg::CFG_END_GREEN:   end_c[1] = val[lrgbf_pkg::CHANNEL_WIDTH-1:0];
                lrgbf_pkg::CFG_END_BLUE:    end_c[2] = val[lrgbf_pkg::CHANNEL_WIDTH-1:0];
                lrgbf_pkg::CFG_DURATION:    duration = val;
                default:                    ;
            endcase
        endfunction

        // start + round(span * elapsed / duration), half away from zero
        function lrgbf_pkg::chan_t blend(int c);
            logic [63:0] span;
            logic [63:0] prod;
            logic [63:0] q;
            logic [63:0] r;
            if (elapsed_us == 0 || start_c[c] == end_c[c])
                return start_c[c];
            if (elapsed_us >= duration)
                return end_c[c];
            if (end_c[c] > start_c[c])
                span = {56'b0, lrgbf_pkg::chan_t'(end_c[c] - start_c[c])};
            else
                span = {56'b0, lrgbf_pkg::chan_t'(start_c[c] - end_c[c])};
            prod = span * {32'b0, elapsed_us};
            q = prod / {32'b0, duration};
            r = prod % {32'b0, duration};
            if ((r << 1) >= {32'b0, duration})
                q = q + 64'd1;
            if (end_c[c] > start_c[c])
                return start_c[c] + q[lrgbf_pkg::CHANNEL_WIDTH-1:0];
            return start_c[c] - q[lrgbf_pkg::CHANNEL_WIDTH-1:0];
        endfunction

        function void note_tick(lrgbf_pkg::time_t delta, logic rs);
            fade_color_t e;
            if (rs)
            begin
                elapsed_us = '0;
                finished = 1'b0;
            end
            if (elapsed_us >= duration)
                finished = 1'b1;
            else if (delta != 0)
            begin
                if (delta >= duration - elapsed_us)
                    elapsed_us = duration;
                else
                    elapsed_us = elapsed_us + delta;
            end
            e.red = blend(0);
            e.green = blend(1);
            e.blue = blend(2);
            e.elapsed = elapsed_us;
            e.done = finished;
            colors_due.push_back(e);
        endfunction

        function void check_color(lrgbf_pkg::chan_t r, lrgbf_pkg::chan_t g,
                                  lrgbf_pkg::chan_t b, lrgbf_pkg::time_t el, logic dn);
            fade_color_t e;
            if (colors_due.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            e = colors_due.pop_front();
            if (r !== e.red)
            begin
                $error("red: expected %0d, got %0d", e.red, r);
                mismatches++;
            end
            if (g !== e.green)
            begin
                $error("green: expected %0d, got %0d", e.green, g);
                mismatches++;
            end
            if (b !== e.blue)
            begin
                $error("blue: expected %0d, got %0d", e.blue, b);
                mismatches++;
            end
            if (el !== e.elapsed)
            begin
                $error("elapsed: expected %0d, got %0d", e.elapsed, el);
                mismatches++;
            end
            if (dn !== e.done)
            begin
                $error("done_res: expected %0d, got %0d", e.done, dn);
                mismatches++;
            end
        endfunction

        function int pending();
            return colors_due.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [lrgbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    lrgbf_pkg::time_t                cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    lrgbf_pkg::time_t                delta_us = '0;
    logic                            restart = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    lrgbf_pkg::chan_t                red;
    lrgbf_pkg::chan_t                green;
    lrgbf_pkg::chan_t                blue;
    lrgbf_pkg::time_t                elapsed;
    logic                            done_res;

    fade_tracker tracker;
    int          ticks_sent = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;

    linear_rgb_fade_engine_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .delta_us  (delta_us),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .elapsed   (elapsed),
        .done_res  (done_res)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_color(red, green, blue, elapsed, done_res);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                n = 400;
            end
            else if (rx_idle && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 14);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 20);
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [lrgbf_pkg::CFG_IDX_W-1:0] idx,
                             input lrgbf_pkg::time_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic load_fade(input lrgbf_pkg::chan_t sr, input lrgbf_pkg::chan_t sg,
                             input lrgbf_pkg::chan_t sb, input lrgbf_pkg::chan_t er,
                             input lrgbf_pkg::chan_t eg, input lrgbf_pkg::chan_t eb,
                             input lrgbf_pkg::time_t dur);
        write_reg(lrgbf_pkg::CFG_START_RED, ($urandom << lrgbf_pkg::CHANNEL_WIDTH) | sr);
        write_reg(lrgbf_pkg::CFG_START_GREEN, ($urandom << lrgbf_pkg::CHANNEL_WIDTH) | sg);
        write_reg(lrgbf_pkg::CFG_START_BLUE, ($urandom << lrgbf_pkg::CHANNEL_WIDTH) | sb);
        write_reg(lrgbf_pkg::CFG_END_RED, ($urandom << lrgbf_pkg::CHANNEL_WIDTH) | er);
        write_reg(lrgbf_pkg::CFG_END_GREEN, ($urandom << lrgbf_pkg::CHANNEL_WIDTH) | eg);
        write_reg(lrgbf_pkg::CFG_END_BLUE, ($urandom << lrgbf_pkg::CHANNEL_WIDTH) | eb);
        write_reg(lrgbf_pkg::CFG_DURATION, dur);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input lrgbf_pkg::time_t d, input logic rs);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        delta_us <= d;
        restart <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_tick(d, rs);
        ticks_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int               n;
        int               sel;
        int               j;
        int               phase;
        lrgbf_pkg::chan_t c [6];
        lrgbf_pkg::time_t dur;
        lrgbf_pkg::time_t step;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero duration straight after reset
        send_tick(32'd0, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b1);
        wait_drain();

        load_fade(8'd0, 8'd255, 8'd100, 8'd255, 8'd0, 8'd100, 32'd1000);
        send_tick(32'd0, 1'b1);
        send_tick(32'd1, 1'b0);
        send_tick(32'd499, 1'b0);
        send_tick(32'd0, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b0);
        send_tick(32'd5, 1'b0);
        send_tick(32'd700, 1'b1);
        wait_drain();
        // duration pulled below elapsed
        write_reg(lrgbf_pkg::CFG_DURATION, 32'd300);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_tick(32'd3, 1'b0);
        send_tick(32'd0, 1'b0);
        wait_drain();

        load_fade(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_tick(32'h8000_0000, 1'b1);
        send_tick(32'h7FFF_FFFF, 1'b0);
        send_tick(32'd1, 1'b0);
        send_tick(32'h5555_5555, 1'b1);
        send_tick(32'hAAAA_AAAA, 1'b0);
        wait_drain();

        load_fade(8'd255, 8'd0, 8'd17, 8'd0, 8'd255, 8'd17, 32'd1);
        send_tick(32'd0, 1'b1);
        send_tick(32'd1, 1'b0);
        send_tick(32'd1, 1'b0);
        wait_drain();

        phase = 0;
        while (ticks_sent < 1250)
        begin
            phase++;
            tx_idle = (ticks_sent < 1100) && (phase % 4 != 1) && (phase != 3);
            rx_idle = (ticks_sent < 1100) && (phase % 4 != 2);

            for (int i = 0; i < 6; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       c[i] = '0;
                    1:       c[i] = '1;
                    default: c[i] = lrgbf_pkg::chan_t'($urandom_range(0, 255));
                endcase
            end
            if ($urandom_range(0, 2) == 0)
            begin
                j = $urandom_range(0, 2);
                c[j + 3] = c[j];
            end
            case ($urandom_range(0, 9))
                0:       dur = '0;
                1:       dur = 32'hFFFF_FFFF;
                2:       dur = 32'd1;
                3, 4, 5: dur = $urandom_range(2, 40);
                default: dur = $urandom >> $urandom_range(0, 28);
            endcase
            load_fade(c[0], c[1], c[2], c[3], c[4], c[5], dur);

            n = $urandom_range(8, 40);
            if (phase == 3)
            begin
                hold_req = 1'b1;
                n = 20;
            end
            for (int k = 0; k < n; k++)
            begin
                sel = $urandom_range(0, 9);
                step = (dur >> $urandom_range(1, 6)) + $urandom_range(0, 2);
                if (k == 0)
                    send_tick(step, 1'b1);
                else if (sel < 7)
                    send_tick(step, 1'b0);
                else if (sel == 7)
                    send_tick($urandom, 1'($urandom_range(0, 1)));
                else if (sel == 8)
                    send_tick(32'd0, 1'b0);
                else
                    send_tick(step, 1'b1);
            end
            wait_drain();

            if ($urandom_range(0, 4) == 0 && tracker.elapsed_us > 1)
            begin
                write_reg(lrgbf_pkg::CFG_DURATION, tracker.elapsed_us >> 1);
                cfg_we <= 1'b0;
                @(posedge clk);
                send_tick($urandom_range(0, 100), 1'b0);
                send_tick(32'd0, 1'b0);
                wait_drain();
            end
        end

        wait_drain();
        repeat (60) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- linear_rgb_fade_engine_core.f -----
rtl/core/lrgbf_pkg.sv
rtl/core/lrgbf_unit.sv
rtl/core/linear_rgb_fade_engine_core.sv
test/tb.sv
